// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the cache tag block.
// Simulation gets concurrent checks; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("%m failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error("%m failed");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEVER(lbl, prop)
`endif
`endif

// ===== hdl/sactp_pkg.sv =====
// Package of the cache tag block: geometry constants, command codes, queue entry type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sactp_pkg;
  localparam int unsigned Ways      = 4;
  localparam int unsigned Sets      = 64;
  localparam int unsigned LineBytes = 32;
  localparam int unsigned Lines     = Ways * Sets;
  localparam int unsigned WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SetW      = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned LineW     = $clog2(Lines);
  localparam int unsigned LbW       = $clog2(LineBytes);
  localparam int unsigned TagW      = 32 - LbW;
  localparam logic [15:0] LfsrReset = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_PREPARE = 2'd0,
    CMD_ACCESS  = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_INVAL   = 2'd3
  } cmd_e;

  localparam logic CFG_RANDOM = 1'b0;
  localparam logic CFG_BANK   = 1'b1;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_e             cmd;
    logic [SetW-1:0]  set;
    logic [WayW-1:0]  way;
    logic             in_range;
    logic [TagW-1:0]  tag;
    logic             is_write;
    logic             fill_dirty;
    logic             random;
    logic [7:0]       index;
  } req_t;
endpackage
`default_nettype wire

// ===== hdl/sactp_front.sv =====
// Front end: decodes a request and computes its set, way and tag.
// Depends on sactp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sactp_front (
  input  wire logic [1:0]         cmd_i,
  input  wire logic [31:0]        address_i,
  input  wire logic [7:0]         line_index_i,
  input  wire logic               is_write_i,
  input  wire logic               fill_dirty_i,
  input  wire logic               random_mode_i,
  input  wire logic [2:0]         bank_select_bits_i,
  output sactp_pkg::req_t         req_o
);
  logic [31:0] shifted;

  // Classify the request
  always_comb begin
    shifted             = address_i >> (sactp_pkg::LbW + 32'(bank_select_bits_i));
    req_o.cmd           = sactp_pkg::cmd_e'(cmd_i);
    req_o.set           = (cmd_i == sactp_pkg::CMD_PREPARE) ? shifted[sactp_pkg::SetW-1:0]
                        : line_index_i[sactp_pkg::LineW-1:sactp_pkg::WayW];
    req_o.way           = line_index_i[sactp_pkg::WayW-1:0];
    req_o.in_range      = 32'(line_index_i) < sactp_pkg::Lines;
    req_o.tag           = address_i[31:sactp_pkg::LbW];
    req_o.is_write      = is_write_i;
    req_o.fill_dirty    = fill_dirty_i;
    req_o.random        = random_mode_i;
    req_o.index         = line_index_i;
  end
endmodule
`default_nettype wire

// ===== hdl/sactp_queue.sv =====
// Two-entry request queue between front and back ends.
// Depends on sactp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sactp_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  sactp_pkg::req_t data_i,
  output logic            full_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output sactp_pkg::req_t data_o
);
  sactp_pkg::req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sactp_back.sv =====
// Back end: read-modify-write of one set row (tags in memory, valid/dirty in flops),
// plus the LFSR of random replacement. Depends on sactp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sactp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  sactp_pkg::req_t        req_i,
  output logic                   pop_o,
  output logic                   busy_o,
  output logic                   done_o,
  output logic                   hit_o,
  output logic [7:0]             line_slot_o,
  output logic                   flush_needed_o,
  output logic [31:0]            flush_address_o,
  output logic                   fault_o
);
  localparam int unsigned W  = sactp_pkg::Ways;
  localparam int unsigned TW = sactp_pkg::TagW;

  typedef enum logic [1:0] {
    ST_READ  = 2'b01,
    ST_WRITE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [W*TW-1:0] tag_mem [sactp_pkg::Sets];
  logic [W*TW-1:0] row_q, row_d;
  logic [W-1:0]    valid_q [sactp_pkg::Sets];
  logic [W-1:0]    dirty_q [sactp_pkg::Sets];
  logic [W-1:0]    vrow_q, drow_q;
  logic [W-1:0]    vrow_d, drow_d, vrow, drow;
  logic            rd_en;
  logic            wr_en;
  logic [15:0]     lfsr_q, lfsr_d;
  logic [TW-1:0]   t_cur;
  logic [TW-1:0]   t_sel;
  logic            found;
  logic [sactp_pkg::WayW-1:0] hway, slot_way, victim;
  logic            res_hit, res_flush, res_fault;
  logic [31:0]     res_faddr;
  logic [7:0]      res_slot;

  // Read the head request in the read state, retire it in the write state
  assign rd_en  = state_q == ST_READ && !empty_i;
  assign pop_o  = state_q == ST_WRITE;
  assign busy_o = state_q == ST_WRITE;

  // Read the set row and write back its tags
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      row_q  <= tag_mem[req_i.set];
      vrow_q <= valid_q[req_i.set];
      drow_q <= dirty_q[req_i.set];
    end
    if (wr_en) begin
      tag_mem[req_i.set] <= row_d;
    end
  end

  assign vrow = vrow_q;
  assign drow = drow_q;

  // Pick the miss victim: oldest way, or the LFSR in random mode
  assign victim = req_i.random ? lfsr_q[sactp_pkg::WayW-1:0]
                               : sactp_pkg::WayW'(sactp_pkg::Ways - 1);

  // Compute result and the new row
  always_comb begin
    row_d = row_q; vrow_d = vrow; drow_d = drow;
    lfsr_d = lfsr_q;
    found = 1'b0; hway = '0; t_cur = '0; t_sel = '0;
    res_hit = 1'b0; res_flush = 1'b0; res_fault = 1'b0; res_faddr = '0;
    slot_way = req_i.way;
    res_slot = req_i.index;
    wr_en = 1'b0;
    case (req_i.cmd)
      sactp_pkg::CMD_PREPARE: begin
        for (int w = W - 1; w >= 0; w--) begin
          t_cur = row_q[w*TW +: TW];
          if (vrow[w] && t_cur == req_i.tag) begin
            found = 1'b1;
            hway  = sactp_pkg::WayW'(w);
          end
        end
        slot_way = found ? hway : victim;
        res_hit  = found;
        res_slot = 8'({req_i.set, slot_way});
        t_sel    = row_q[slot_way*TW +: TW];
        if (!found && vrow[slot_way] && drow[slot_way]) begin
          res_flush = 1'b1;
          res_faddr = {t_sel, sactp_pkg::LbW'(0)};
        end
        // Step the LFSR only when a random victim was taken
        if (!found && req_i.random) begin
          lfsr_d = {lfsr_q[5] ^ lfsr_q[3] ^ lfsr_q[2] ^ lfsr_q[0], lfsr_q[15:1]};
        end
      end
      sactp_pkg::CMD_ACCESS: begin
        if (!req_i.in_range || !vrow[req_i.way]) begin
          res_fault = 1'b1;
        end else begin
          if (req_i.is_write) drow_d[req_i.way] = 1'b1;
          if (!req_i.random) begin
            // Move the line to way 0, shift the ones before it back
            for (int w = W - 1; w >= 1; w--) begin
              if (w <= int'(req_i.way)) begin
                row_d[w*TW +: TW] = row_q[(w-1)*TW +: TW];
                vrow_d[w] = vrow[w-1];
                drow_d[w] = drow[w-1];
              end
            end
            row_d[0 +: TW] = row_q[req_i.way*TW +: TW];
            vrow_d[0] = vrow[req_i.way];
            drow_d[0] = req_i.is_write | drow[req_i.way];
            res_slot  = 8'({req_i.set, sactp_pkg::WayW'(0)});
            wr_en     = 1'b1;
          end
        end
      end
      sactp_pkg::CMD_FILL: begin
        if (req_i.in_range) begin
          row_d[req_i.way*TW +: TW] = req_i.tag;
          vrow_d[req_i.way] = 1'b1;
          drow_d[req_i.way] = req_i.fill_dirty;
          wr_en = 1'b1;
        end
      end
      default: begin
        if (req_i.in_range) vrow_d[req_i.way] = 1'b0;
      end
    endcase
    if (state_q != ST_WRITE) begin
      wr_en  = 1'b0;
      lfsr_d = lfsr_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_READ:  if (!empty_i) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_READ;
      default:  state_d = ST_READ;
    endcase
  end

  // Update state, flags, LFSR and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READ;
      done_o  <= 1'b0;
      lfsr_q  <= sactp_pkg::LfsrReset;
      for (int s = 0; s < int'(sactp_pkg::Sets); s++) begin
        valid_q[s] <= '0;
        dirty_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_o  <= state_q == ST_WRITE;
      lfsr_q  <= lfsr_d;
      if (state_q == ST_WRITE) begin
        valid_q[req_i.set] <= vrow_d;
        dirty_q[req_i.set] <= drow_d;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      hit_o           <= res_hit;
      line_slot_o     <= res_slot;
      flush_needed_o  <= res_flush;
      flush_address_o <= res_faddr;
      fault_o         <= res_fault;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/set_assoc_cache_tag_policy.sv =====
// Top level of the set-associative cache tag store with LRU or random replacement.
// Instantiates sactp_front, sactp_queue and sactp_back; uses sactp_pkg and assert_macros.svh.
//
// Usage: drive a request (cmd_i, address_i, line_index_i, is_write_i, fill_dirty_i) with
// start; it is taken at an edge where start is high and busy is low. Each request
// yields one result on hit_o, line_slot_o, flush_needed_o, flush_address_o, fault_o,
// marked by a one-cycle done_o strobe; the receiver cannot stall it.
// Configuration: cfg_we_i, cfg_index_i, cfg_data_i write random_mode (0) and
// bank_select_bits (1) at any edge with cfg_we_i high; write only while idle.
// Result path: an accepted request waits in the queue, is read in the back end's read state,
// and is retired in its write state, which loads the result registers and done_o.
// The back end handles one request at a time, by the read-modify-write of one set row
// in the tag memory (read state, write state). A two-entry queue decouples the front end;
// busy rises while the queue is full.
// Reset: all lines invalid and clean, LFSR at all ones, LRU mode, bank select of 3.
// Tags are not cleared: valid bits guard them.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module set_assoc_cache_tag_policy (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] address_i,
  input  wire logic [7:0]  line_index_i,
  input  wire logic        is_write_i,
  input  wire logic        fill_dirty_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [2:0]  cfg_data_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [7:0]       line_slot_o,
  output logic             flush_needed_o,
  output logic [31:0]      flush_address_o,
  output logic             fault_o
);
  logic            random_mode_q;
  logic [2:0]      bank_select_bits_q;
  logic            accept, full, empty, pop, back_busy;
  sactp_pkg::req_t req_in, req_out;

  assign busy   = full;
  assign accept = start && !busy;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      random_mode_q      <= 1'b0;
      bank_select_bits_q <= 3'd3;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sactp_pkg::CFG_RANDOM) random_mode_q <= cfg_data_i[0];
      if (cfg_index_i == sactp_pkg::CFG_BANK)   bank_select_bits_q <= cfg_data_i;
    end
  end

  sactp_front u_front (
    .cmd_i, .address_i, .line_index_i, .is_write_i, .fill_dirty_i,
    .random_mode_i      (random_mode_q),
    .bank_select_bits_i (bank_select_bits_q),
    .req_o              (req_in)
  );

  sactp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (accept),
    .data_i  (req_in),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (req_out)
  );

  sactp_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .req_i   (req_out),
    .pop_o   (pop),
    .busy_o  (back_busy),
    .done_o, .hit_o, .line_slot_o, .flush_needed_o, .flush_address_o, .fault_o
  );

  `ASSERT_NEVER(a_pop_empty, pop && empty)
  `ASSERT_IMPL(a_done_after_write, $past(back_busy) == done_o)
  `ASSERT_IMPL(a_pop_in_write, pop == back_busy)
endmodule
`default_nettype wire

// ===== dv/set_assoc_cache_tag_policy_tb.sv =====
// Self-checking testbench of set_assoc_cache_tag_policy: a queue-fed driver, a strobe monitor
// and a predictor of the tag, valid and dirty store. Depends on sactp_pkg and the block's RTL.
`timescale 1ns / 1ps
module set_assoc_cache_tag_policy_tb;

  typedef struct {
    sactp_pkg::cmd_e cmd;
    logic [31:0] addr;
    logic [7:0]  idx;
    logic        wr;
    logic        fdirty;
  } tag_req_t;

  typedef struct {
    logic        hit;
    logic [7:0]  slot;
    logic        flush;
    logic [31:0] faddr;
    logic        fault;
  } tag_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [31:0] address_i;
  logic [7:0]  line_index_i;
  logic        is_write_i;
  logic        fill_dirty_i;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [2:0]  cfg_data_i;
  logic        done_o;
  logic        hit_o;
  logic [7:0]  line_slot_o;
  logic        flush_needed_o;
  logic [31:0] flush_address_o;
  logic        fault_o;

  // Predictor state
  logic [26:0] shadow_tag [sactp_pkg::Lines];
  logic        shadow_valid [sactp_pkg::Lines];
  logic        shadow_dirty [sactp_pkg::Lines];
  logic [15:0] shadow_lfsr;
  logic        mode_random;
  logic [2:0]  bank_bits;

  tag_req_t pending_reqs[$];
  tag_rsp_t expected_rsps[$];
  tag_req_t cur_req;
  int       mismatches;
  int       gap_left;
  bit       allow_idle;

  set_assoc_cache_tag_policy i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .address_i, .line_index_i, .is_write_i,
    .fill_dirty_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .done_o, .hit_o, .line_slot_o,
    .flush_needed_o, .flush_address_o, .fault_o
  );

  always #2 clk_i = ~clk_i;

  // Compute the result of one request and update the shadow store
  function automatic tag_rsp_t predict_lookup(tag_req_t r);
    tag_rsp_t   o;
    int         base;
    int         slot;
    logic       nb;
    logic [26:0] t;
    logic        v;
    logic        d;
    o = '{hit: 1'b0, slot: r.idx, flush: 1'b0, faddr: '0, fault: 1'b0};
    case (r.cmd)
      sactp_pkg::CMD_PREPARE: begin
        base = ((r.addr >> (sactp_pkg::LbW + bank_bits)) % sactp_pkg::Sets) * sactp_pkg::Ways;
        for (int w = 0; w < sactp_pkg::Ways; w++) begin
          if (!o.hit && shadow_valid[base + w] &&
              shadow_tag[base + w] == r.addr[31:sactp_pkg::LbW]) begin
            o.hit = 1'b1;
            o.slot = 8'(base + w);
          end
        end
        if (!o.hit) begin
          if (mode_random) begin
            slot = base + (shadow_lfsr % sactp_pkg::Ways);
            nb = shadow_lfsr[5] ^ shadow_lfsr[3] ^ shadow_lfsr[2] ^ shadow_lfsr[0];
            shadow_lfsr = {nb, shadow_lfsr[15:1]};
          end else begin
            slot = base + sactp_pkg::Ways - 1;
          end
          o.slot = 8'(slot);
          if (shadow_valid[slot] && shadow_dirty[slot]) begin
            o.flush = 1'b1;
            o.faddr = {shadow_tag[slot], 5'd0};
          end
        end
      end
      sactp_pkg::CMD_ACCESS: begin
        slot = int'(r.idx);
        if (!shadow_valid[slot]) begin
          o.fault = 1'b1;
        end else begin
          if (r.wr) shadow_dirty[slot] = 1'b1;
          if (!mode_random) begin
            base = (slot / sactp_pkg::Ways) * sactp_pkg::Ways;
            t = shadow_tag[slot];
            v = shadow_valid[slot];
            d = shadow_dirty[slot];
            for (int s = slot; s > base; s--) begin
              shadow_tag[s] = shadow_tag[s - 1];
              shadow_valid[s] = shadow_valid[s - 1];
              shadow_dirty[s] = shadow_dirty[s - 1];
            end
            shadow_tag[base] = t;
            shadow_valid[base] = v;
            shadow_dirty[base] = d;
            o.slot = 8'(base);
          end
        end
      end
      sactp_pkg::CMD_FILL: begin
        shadow_tag[r.idx] = r.addr[31:sactp_pkg::LbW];
        shadow_valid[r.idx] = 1'b1;
        shadow_dirty[r.idx] = r.fdirty;
      end
      default: shadow_valid[r.idx] = 1'b0;
    endcase
    return o;
  endfunction

  // Driver: predict on acceptance, then load the next request or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
      address_i <= '0;
      line_index_i <= '0;
      is_write_i <= 1'b0;
      fill_dirty_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) expected_rsps.push_back(predict_lookup(cur_req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (allow_idle && pending_reqs.size() > 0 && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 7);
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          cmd_i <= cur_req.cmd;
          address_i <= cur_req.addr;
          line_index_i <= cur_req.idx;
          is_write_i <= cur_req.wr;
          fill_dirty_i <= cur_req.fdirty;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result strobe at %0t", $realtime);
      end else begin
        tag_rsp_t e;
        e = expected_rsps.pop_front();
        if (hit_o !== e.hit || line_slot_o !== e.slot || flush_needed_o !== e.flush ||
            flush_address_o !== e.faddr || fault_o !== e.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp hit %b slot %0d flush %b addr %h fault %b,",
                     $realtime, e.hit, e.slot, e.flush, e.faddr, e.fault,
                     " got hit %b slot %0d flush %b addr %h fault %b",
                     hit_o, line_slot_o, flush_needed_o, flush_address_o, fault_o);
        end
      end
    end
  end

  task automatic add_req(sactp_pkg::cmd_e c, logic [31:0] a, logic [7:0] i, logic w,
                         logic f);
    pending_reqs.push_back('{cmd: c, addr: a, idx: i, wr: w, fdirty: f});
  endtask

  function automatic logic [7:0] slot_of(logic [31:0] a, int way);
    return 8'(((a >> (sactp_pkg::LbW + bank_bits)) % sactp_pkg::Sets) * sactp_pkg::Ways
              + way);
  endfunction

  // Hold until every request is sent and answered, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [2:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sactp_pkg::CFG_RANDOM) mode_random = val[0];
    else bank_bits = val;
  endtask

  // Mostly lookup/fill/access traffic on a small address pool, plus noise
  task automatic random_traffic(int n);
    logic [31:0] pool [12];
    logic [31:0] a;
    foreach (pool[k]) pool[k] = $urandom();
    for (int k = 0; k < n; k++) begin
      a = pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 3) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_req(sactp_pkg::CMD_PREPARE, a, 8'($urandom()), 1'($urandom()),
                            1'($urandom()));
        4, 5: add_req(sactp_pkg::CMD_FILL, a,
                      slot_of(a, $urandom_range(0, sactp_pkg::Ways - 1)), 1'($urandom()),
                      1'($urandom()));
        6, 7: add_req(sactp_pkg::CMD_ACCESS, a,
                      slot_of(a, $urandom_range(0, sactp_pkg::Ways - 1)), 1'($urandom()),
                      1'($urandom()));
        8: add_req(sactp_pkg::CMD_INVAL, a,
                   slot_of(a, $urandom_range(0, sactp_pkg::Ways - 1)), 1'($urandom()),
                   1'($urandom()));
        default: add_req(sactp_pkg::cmd_e'($urandom_range(0, 3)), $urandom(),
                         8'($urandom()), 1'($urandom()), 1'($urandom()));
      endcase
    end
  endtask

  initial begin
    #2000000;
    $display("set_assoc_cache_tag_policy regression: fail");
    $finish;
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_index_i = sactp_pkg::CFG_RANDOM;
    cfg_data_i = '0;
    mismatches = 0;
    allow_idle = 1'b1;
    mode_random = 1'b0;
    bank_bits = 3'd3;
    shadow_lfsr = sactp_pkg::LfsrReset;
    foreach (shadow_valid[k]) begin
      shadow_valid[k] = 1'b0;
      shadow_dirty[k] = 1'b0;
      shadow_tag[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: hits, dirty victims, faults, invalidate, address extremes
    add_req(sactp_pkg::CMD_PREPARE, 32'h0000_0000, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_FILL, 32'h0000_0000, 8'd0, 1'b0, 1'b1);
    add_req(sactp_pkg::CMD_PREPARE, 32'h0000_0000, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_FILL, 32'h4000_0000, 8'd1, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_FILL, 32'h8000_0000, 8'd2, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_FILL, 32'hFFFF_C000, 8'd3, 1'b0, 1'b1);
    add_req(sactp_pkg::CMD_PREPARE, 32'h1234_0000, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_ACCESS, 32'h0, 8'd1, 1'b1, 1'b0);
    add_req(sactp_pkg::CMD_ACCESS, 32'h0, 8'd255, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_PREPARE, 32'h8000_0000, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_PREPARE, 32'h1234_0000, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_INVAL, 32'h0, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_ACCESS, 32'h0, 8'd0, 1'b1, 1'b1);
    add_req(sactp_pkg::CMD_PREPARE, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_FILL, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1);
    add_req(sactp_pkg::CMD_PREPARE, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_ACCESS, 32'h0, 8'd255, 1'b0, 1'b0);
    add_req(sactp_pkg::CMD_PREPARE, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1);
    add_req(sactp_pkg::CMD_INVAL, 32'hFFFF_FFFF, 8'd252, 1'b1, 1'b1);
    add_req(sactp_pkg::CMD_PREPARE, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0);
    wait_idle();
    random_traffic(80);
    wait_idle();

    // Sweep settings, extremes included
    write_cfg(sactp_pkg::CFG_BANK, 3'd0);
    random_traffic(90);
    wait_idle();
    write_cfg(sactp_pkg::CFG_RANDOM, 3'd1);
    write_cfg(sactp_pkg::CFG_BANK, 3'd4);
    random_traffic(100);
    wait_idle();
    write_cfg(sactp_pkg::CFG_BANK, 3'd7);
    random_traffic(90);
    wait_idle();
    write_cfg(sactp_pkg::CFG_RANDOM, 3'd0);
    write_cfg(sactp_pkg::CFG_BANK, 3'd5);
    random_traffic(90);
    wait_idle();
    write_cfg(sactp_pkg::CFG_RANDOM, 3'd1);
    write_cfg(sactp_pkg::CFG_BANK, 3'd1);
    random_traffic(90);
    wait_idle();
    write_cfg(sactp_pkg::CFG_RANDOM, 3'd0);
    write_cfg(sactp_pkg::CFG_BANK, 3'd2);
    random_traffic(80);
    wait_idle();
    write_cfg(sactp_pkg::CFG_BANK, 3'd6);
    allow_idle = 1'b0;
    random_traffic(80);
    wait_idle();

    if (mismatches == 0) $display("set_assoc_cache_tag_policy regression: pass");
    else $display("set_assoc_cache_tag_policy regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sactp_pkg.sv
hdl/sactp_front.sv
hdl/sactp_queue.sv
hdl/sactp_back.sv
hdl/set_assoc_cache_tag_policy.sv
dv/set_assoc_cache_tag_policy_tb.sv
